// ----- rtl/mfp_pkg.sv -----
// Package for the multi-format pixel to RGBA converter.
// Holds widths, mode codes, item types and the palette tables; no dependencies.
package mfp_pkg;

	localparam int ADDRESS_BITS = 24;
	localparam int COORD_BITS   = 12;

	localparam logic [3:0] MODE_MONO_BLACK = 4'd0;
	localparam logic [3:0] MODE_MONO_WHITE = 4'd1;
	localparam logic [3:0] MODE_BRIGHT     = 4'd2;
	localparam logic [3:0] MODE_PAL128     = 4'd3;
	localparam logic [3:0] MODE_GRAY2      = 4'd4;
	localparam logic [3:0] MODE_RGB555     = 4'd5;
	localparam logic [3:0] MODE_PAL512     = 4'd6;
	localparam logic [3:0] MODE_GRAY4      = 4'd7;
	localparam logic [3:0] MODE_RGB222     = 4'd8;
	localparam logic [3:0] MODE_RGB444     = 4'd9;
	localparam logic [3:0] MODE_PASS       = 4'd10;

	localparam logic [2:0] REG_MODE       = 3'd0;
	localparam logic [2:0] REG_COL_ORIGIN = 3'd1;
	localparam logic [2:0] REG_ROW_ORIGIN = 3'd2;
	localparam logic [2:0] REG_ROW_PITCH  = 3'd3;
	localparam logic [2:0] REG_EVENT_VIEW = 3'd4;

	localparam logic [12:0] ROW_PITCH_RESET = 13'd640;

	// classified item handed from front to back
	typedef struct packed {
		logic [3:0]            mode;
		logic [31:0]           pixel;
		logic [COORD_BITS:0]   row_base;   // row index incl. row origin when used
		logic [COORD_BITS:0]   col;        // column incl. column origin or event column
		logic                  last;
	} item_t;

	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);

	function automatic logic [9:0] src_width(input logic [3:0] m);
		case (m)
			MODE_MONO_BLACK: return 10'd512;
			MODE_MONO_WHITE: return 10'd280;
			MODE_BRIGHT:     return 10'd352;
			MODE_PAL128, MODE_GRAY2, MODE_RGB555: return 10'd160;
			MODE_GRAY4:      return 10'd320;
			MODE_PASS:       return 10'd640;
			default:         return 10'd256;
		endcase
	endfunction

	function automatic logic [8:0] src_height(input logic [3:0] m);
		case (m)
			MODE_MONO_BLACK: return 9'd342;
			MODE_BRIGHT:     return 9'd304;
			MODE_GRAY2, MODE_RGB555: return 9'd144;
			MODE_PAL512:     return 9'd240;
			MODE_GRAY4:      return 9'd224;
			MODE_PASS:       return 9'd480;
			default:         return 9'd192;
		endcase
	endfunction

	function automatic logic uses_offset(input logic [3:0] m);
		case (m)
			MODE_MONO_WHITE, MODE_GRAY2, MODE_RGB555, MODE_PAL512,
			MODE_RGB222, MODE_RGB444: return 1'b1;
			default: return 1'b0;
		endcase
	endfunction

	function automatic logic [31:0] swap_rb(input logic [31:0] v);
		return {v[31:24], v[7:0], v[15:8], v[23:16]};
	endfunction

	localparam logic [31:0] BRIGHT_PAL [16] = '{
		32'hFF000000, 32'hFF0000D8, 32'hFFD80000, 32'hFFD800D8,
		32'hFF00D800, 32'hFF00D8D8, 32'hFFD8D800, 32'hFFD8D8D8,
		32'hFF000000, 32'hFF0000FF, 32'hFFFF0000, 32'hFFFF00FF,
		32'hFF00FF00, 32'hFF00FFFF, 32'hFFFFFF00, 32'hFFFFFFFF
	};

	localparam logic [23:0] PAL_SMALL [128] = '{
		24'h000000, 24'h444400, 24'h702800, 24'h841800, 24'h880000, 24'h78005c, 24'h480078,
		24'h140084, 24'h000088, 24'h00187c, 24'h002c5c, 24'h00402c, 24'h003c00, 24'h143800,
		24'h2c3000, 24'h442800, 24'h404040, 24'h646410, 24'h844414, 24'h983418, 24'h9c2020,
		24'h8c2074, 24'h602090, 24'h302098, 24'h1c209c, 24'h1c3890, 24'h1c4c78, 24'h1c5c48,
		24'h205c20, 24'h345c1c, 24'h4c501c, 24'h644818, 24'h6c6c6c, 24'h848424, 24'h985c28,
		24'hac5030, 24'hb03c3c, 24'ha03c88, 24'h783ca4, 24'h4c3cac, 24'h3840b0, 24'h3854a8,
		24'h386890, 24'h387c64, 24'h407c40, 24'h507c38, 24'h687034, 24'h846830, 24'h909090,
		24'ha0a034, 24'hac783c, 24'hc06848, 24'hc05858, 24'hb0589c, 24'h8c58b8, 24'h6858c0,
		24'h505cc0, 24'h5070bc, 24'h5084ac, 24'h509c80, 24'h5c9c5c, 24'h6c9850, 24'h848c4c,
		24'ha08444, 24'hb0b0b0, 24'hb8b840, 24'hbc8c4c, 24'hd0805c, 24'hd07070, 24'hc070b0,
		24'ha070cc, 24'h7c70d0, 24'h6874d0, 24'h6888cc, 24'h689cc0, 24'h68b494, 24'h74b474,
		24'h84b468, 24'h9ca864, 24'hb89c58, 24'hc8c8c8, 24'hd0d050, 24'hcca05c, 24'he09470,
		24'he08888, 24'hd084c0, 24'hb484dc, 24'h9488e0, 24'h7c8ce0, 24'h7c9cdc, 24'h7cb4d4,
		24'h7cd0ac, 24'h8cd08c, 24'h9ccc7c, 24'hb4c078, 24'hd0b46c, 24'hdcdcdc, 24'he8e85c,
		24'hdcb468, 24'heca880, 24'heca0a0, 24'hdc9cd0, 24'hc49cec, 24'ha8a0ec, 24'h90a4ec,
		24'h90b4ec, 24'h90cce8, 24'h90e4c0, 24'ha4e4a4, 24'hb4e490, 24'hccd488, 24'he8cc7c,
		24'hececec, 24'hfcfc68, 24'hfcbc94, 24'hfcb4b4, 24'hecb0e0, 24'hd4b0fc, 24'hbcb4fc,
		24'ha4b8fc, 24'ha4c8fc, 24'ha4e0fc, 24'ha4fcd4, 24'hb8fcb8, 24'hc8fca4, 24'he0ec9c,
		24'hfce08c, 24'hffffff
	};

	localparam logic [23:0] PAL_LARGE [512] = '{
		24'h525252, 24'h011A51, 24'h0F0F65, 24'h230663, 24'h36034B, 24'h400426, 24'h3F0904, 24'h321300,
		24'h1F2000, 24'h0B2A00, 24'h002F00, 24'h002E0A, 24'h00262D, 24'h000000, 24'h000000, 24'h000000,
		24'hA0A0A0, 24'h1E4A9D, 24'h3837BC, 24'h5828B8, 24'h752194, 24'h84235C, 24'h822E24, 24'h6F3F00,
		24'h515200, 24'h316300, 24'h1A6B05, 24'h0E692E, 24'h105C68, 24'h000000, 24'h000000, 24'h000000,
		24'hFEFFFF, 24'h699EFC, 24'h8987FF, 24'hAE76FF, 24'hCE6DF1, 24'hE070B2, 24'hDE7C70, 24'hC8913E,
		24'hA6A725, 24'h81BA28, 24'h63C446, 24'h54C17D, 24'h56B3C0, 24'h3C3C3C, 24'h000000, 24'h000000,
		24'hFEFFFF, 24'hBED6FD, 24'hCCCCFF, 24'hDDC4FF, 24'hEAC0F9, 24'hF2C1DF, 24'hF1C7C2, 24'hE8D0AA,
		24'hD9DA9D, 24'hC9E29E, 24'hBCE6AE, 24'hB4E5C7, 24'hB5DFE4, 24'hA9A9A9, 24'h000000, 24'h000000,
		24'h4B3432, 24'h00072E, 24'h0B0141, 24'h1D0042, 24'h300031, 24'h3B0016, 24'h3D0300, 24'h2F0900,
		24'h1C1000, 24'h091600, 24'h001800, 24'h001500, 24'h000D11, 24'h000000, 24'h000000, 24'h000000,
		24'h94716C, 24'h172767, 24'h301C84, 24'h4F1385, 24'h6B116B, 24'h7C1541, 24'h7E2116, 24'h6A2C00,
		24'h4C3800, 24'h2D4200, 24'h164500, 24'h0A4010, 24'h083239, 24'h000000, 24'h000000, 24'h000000,
		24'hEEBCB5, 24'h5D67B0, 24'h7C59CF, 24'hA04FD1, 24'hC04BB4, 24'hD35184, 24'hD66051, 24'hBF6D25,
		24'h9D7B0F, 24'h79870E, 24'h5C8A22, 24'h4B8449, 24'h49757B, 24'h362321, 24'h000000, 24'h000000,
		24'hEEBCB5, 24'hAF98B3, 24'hBD91C0, 24'hCD8DC0, 24'hDB8BB5, 24'hE38EA1, 24'hE4948A, 24'hDA9A75,
		24'hCCA169, 24'hBCA569, 24'hAFA774, 24'hA7A486, 24'hA69E9D, 24'h9D7873, 24'h000000, 24'h000000,
		24'h2E4527, 24'h00132C, 24'h00073A, 24'h0A0035, 24'h150020, 24'h1F0008, 24'h210300, 24'h190D00,
		24'h0C1900, 24'h012500, 24'h002C00, 24'h002800, 24'h001F13, 24'h000000, 24'h000000, 24'h000000,
		24'h678B5C, 24'h083D64, 24'h182A79, 24'h2D1A72, 24'h401251, 24'h501629, 24'h522204, 24'h463400,
		24'h314800, 24'h1C5900, 24'h0C6400, 24'h025E13, 24'h01503D, 24'h000000, 24'h000000, 24'h000000,
		24'hAEE19D, 24'h3C89A6, 24'h5272BD, 24'h6C5FB6, 24'h815492, 24'h945A64, 24'h966834, 24'h897E12,
		24'h719504, 24'h56A908, 24'h42B621, 24'h33AF48, 24'h319F7A, 24'h1E3118, 24'h000000, 24'h000000,
		24'hAEE19D, 24'h7DBBA1, 24'h86B1AA, 24'h92A9A7, 24'h9BA499, 24'hA3A785, 24'hA4AD70, 24'h9EB75F,
		24'h94C156, 24'h89CA59, 24'h7FCF66, 24'h78CC79, 24'h77C58F, 24'h6E9362, 24'h000000, 24'h000000,
		24'h2D2E1E, 24'h000421, 24'h00002F, 24'h0A002D, 24'h15001D, 24'h1F0006, 24'h200000, 24'h180500,
		24'h0B0C00, 24'h001300, 24'h001600, 24'h001300, 24'h000B0C, 24'h000000, 24'h000000, 24'h000000,
		24'h66664D, 24'h072352, 24'h181767, 24'h2C0E64, 24'h3F094C, 24'h4F0D25, 24'h511802, 24'h442400,
		24'h303100, 24'h1B3C00, 24'h0B4200, 24'h013C09, 24'h002F2F, 24'h000000, 24'h000000, 24'h000000,
		24'hACAC89, 24'h3B5F8E, 24'h5150A5, 24'h6A44A2, 24'h803E87, 24'h93445A, 24'h95522C, 24'h86600D,
		24'h6E7001, 24'h557D02, 24'h408312, 24'h317D36, 24'h2F6E66, 24'h1D1D11, 24'h000000, 24'h000000,
		24'hACAC89, 24'h7B8B8B, 24'h858594, 24'h907F93, 24'h9A7D88, 24'hA17F75, 24'hA28560, 24'h9C8C51,
		24'h929348, 24'h869849, 24'h7D9B53, 24'h769865, 24'h75927A, 24'h6C6C53, 24'h000000, 24'h000000,
		24'h373759, 24'h000F53, 24'h090868, 24'h170063, 24'h24004B, 24'h2A0028, 24'h260007, 24'h1A0300,
		24'h090A00, 24'h001300, 24'h001A00, 24'h001B0E, 24'h001731, 24'h000000, 24'h000001, 24'h000001,
		24'h7575AB, 24'h1337A1, 24'h2C2AC0, 24'h431BB8, 24'h571394, 24'h61125F, 24'h5B172A, 24'h482106,
		24'h2C2D00, 24'h173D00, 24'h08480D, 24'h034937, 24'h06436E, 24'h000001, 24'h000001, 24'h000001,
		24'hC2C1FF, 24'h507BFF, 24'h6E6CFF, 24'h895AFF, 24'hA04FF5, 24'hAB4DBA, 24'hA5547B, 24'h8F614A,
		24'h6F6F30, 24'h558336, 24'h408E55, 24'h38908A, 24'h3D89CA, 24'h252542, 24'h000001, 24'h000001,
		24'hC2C1FF, 24'h91A4FF, 24'h9F9DFF, 24'hAA95FF, 24'hB490FF, 24'hB98FEA, 24'hB692CF, 24'hAD98B8,
		24'h9F9FAB, 24'h93A7AE, 24'h8AACBD, 24'h86ADD6, 24'h88AAF1, 24'h7D7CB4, 24'h000001, 24'h000001,
		24'h322735, 24'h00042F, 24'h050043, 24'h120041, 24'h1E0030, 24'h250017, 24'h240001, 24'h180000,
		24'h080600, 24'h000C00, 24'h000F00, 24'h000E00, 24'h000A12, 24'h000000, 24'h000000, 24'h000000,
		24'h6D5B73, 24'h0D2169, 24'h251686, 24'h3B0D84, 24'h4F096A, 24'h5A0A43, 24'h58101B, 24'h451A00,
		24'h2A2600, 24'h153000, 24'h063600, 24'h003414, 24'h012C3B, 24'h000000, 24'h000000, 24'h000000,
		24'hB69DBE, 24'h455AB4, 24'h634CD4, 24'h7D40D1, 24'h943BB5, 24'hA03C88, 24'h9F4559, 24'h89512C,
		24'h695F15, 24'h506C16, 24'h3C722B, 24'h317051, 24'h33677F, 24'h211824, 24'h000000, 24'h000000,
		24'hB69DBE, 24'h8581BA, 24'h937AC7, 24'h9E75C6, 24'hA872BA, 24'hAD73A8, 24'hAC7793, 24'hA37D7E,
		24'h958371, 24'h8A8872, 24'h818B7D, 24'h7C8A8F, 24'h7C86A3, 24'h73627A, 24'h000000, 24'h000000,
		24'h242F30, 24'h000A2F, 24'h00033D, 24'h070039, 24'h120023, 24'h19000C, 24'h180000, 24'h100100,
		24'h050800, 24'h001100, 24'h001700, 24'h001601, 24'h001117, 24'h000000, 24'h000000, 24'h000000,
		24'h57686A, 24'h042D68, 24'h14207E, 24'h281277, 24'h3B0A56, 24'h450B30, 24'h44120C, 24'h371D00,
		24'h232900, 24'h0F3900, 24'h024401, 24'h00421C, 24'h003943, 24'h000000, 24'h000000, 24'h000000,
		24'h97AFB2, 24'h336BB0, 24'h485CC8, 24'h614AC0, 24'h773F9B, 24'h834170, 24'h814A43, 24'h725821,
		24'h5B6711, 24'h427A16, 24'h2F8631, 24'h258457, 24'h277A86, 24'h161E20, 24'h000000, 24'h000000,
		24'h97AFB2, 24'h6B92B1, 24'h758CBB, 24'h8083B8, 24'h897FA9, 24'h8E7F96, 24'h8E8382, 24'h888A72,
		24'h7E9169, 24'h73996C, 24'h6A9E7A, 24'h659D8B, 24'h6599A0, 24'h5D6E71, 24'h000000, 24'h000000,
		24'h252525, 24'h000323, 24'h000031, 24'h07002F, 24'h120020, 24'h190009, 24'h180000, 24'h100000,
		24'h050500, 24'h000B00, 24'h000F00, 24'h000E00, 24'h00090D, 24'h000000, 24'h000000, 24'h000000,
		24'h585858, 24'h051F56, 24'h14136B, 24'h280A68, 24'h3B0650, 24'h45072B, 24'h440E08, 24'h371800,
		24'h242400, 24'h102F00, 24'h023500, 24'h00330E, 24'h002B32, 24'h000000, 24'h000000, 24'h000000,
		24'h989898, 24'h335696, 24'h4847AC, 24'h613CAA, 24'h77368F, 24'h833864, 24'h814038, 24'h734E18,
		24'h5C5D09, 24'h43690A, 24'h30701D, 24'h266E40, 24'h27646D, 24'h161616, 24'h000000, 24'h000000,
		24'h989898, 24'h6C7C97, 24'h7675A0, 24'h81709F, 24'h8A6D94, 24'h8F6E82, 24'h8E726E, 24'h88785E,
		24'h7E7F56, 24'h738457, 24'h6A8761, 24'h658672, 24'h668286, 24'h5E5E5E, 24'h000000, 24'h000000
	};

endpackage

// ----- rtl/mfp_front.sv -----
// Front part: holds configuration, walks the row/column counters and
// classifies each accepted pixel into an item_t. Uses mfp_pkg.
module mfp_front (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [2:0]                    cfg_index,
	input  logic [12:0]                   cfg_data,
	input  logic                          in_fire,
	input  logic [31:0]                   in_pixel,
	input  logic [mfp_pkg::COORD_BITS-1:0] in_event_column,
	output logic                          push,
	output mfp_pkg::item_t                item,
	output logic [12:0]                   row_pitch
);
	import mfp_pkg::*;

	logic [3:0]            mode_q;
	logic [COORD_BITS-1:0] col_origin_q, row_origin_q;
	logic [12:0]           row_pitch_q;
	logic                  event_view_q;
	logic [9:0]            column_count_q;
	logic [8:0]            row_count_q;
	logic                  col_end, row_end, ev, mode_valid;

	assign mode_valid = (mode_q <= MODE_PASS);
	assign push       = in_fire && mode_valid;
	assign row_pitch  = row_pitch_q;
	assign col_end    = ({1'b0, column_count_q} + 11'd1) >= {1'b0, src_width(mode_q)};
	assign row_end    = ({1'b0, row_count_q} + 10'd1) >= {1'b0, src_height(mode_q)};
	assign ev         = event_view_q && (mode_q == MODE_GRAY2 || mode_q == MODE_RGB555);

	// classify: pick column and row base per placement rule
	always_comb begin
		item.mode  = mode_q;
		item.pixel = in_pixel;
		item.last  = col_end && row_end;
		if (ev) begin
			item.row_base = (COORD_BITS+1)'(row_count_q);
			item.col      = {1'b0, in_event_column};
		end else if (uses_offset(mode_q)) begin
			item.row_base = {1'b0, row_origin_q} + (COORD_BITS+1)'(row_count_q);
			item.col      = {1'b0, col_origin_q} + (COORD_BITS+1)'(column_count_q);
		end else begin
			item.row_base = (COORD_BITS+1)'(row_count_q);
			item.col      = (COORD_BITS+1)'(column_count_q);
		end
	end

	// hold configuration and advance counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q         <= MODE_MONO_BLACK;
			col_origin_q   <= '0;
			row_origin_q   <= '0;
			row_pitch_q    <= ROW_PITCH_RESET;
			event_view_q   <= 1'b0;
			column_count_q <= '0;
			row_count_q    <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_MODE: begin
					mode_q         <= cfg_data[3:0];
					column_count_q <= '0;
					row_count_q    <= '0;
				end
				REG_COL_ORIGIN: col_origin_q <= cfg_data[COORD_BITS-1:0];
				REG_ROW_ORIGIN: row_origin_q <= cfg_data[COORD_BITS-1:0];
				REG_ROW_PITCH:  row_pitch_q  <= cfg_data;
				REG_EVENT_VIEW: event_view_q <= cfg_data[0];
				default: ;
			endcase
		end else if (push) begin
			if (col_end) begin
				column_count_q <= '0;
				row_count_q    <= row_end ? '0 : row_count_q + 9'd1;
			end else begin
				column_count_q <= column_count_q + 10'd1;
			end
		end
	end

endmodule

// ----- rtl/mfp_queue.sv -----
// Short FIFO of classified items between front and back.
// Uses mfp_pkg for item_t and the depth.
module mfp_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  mfp_pkg::item_t push_item,
	output logic           full,
	input  logic           pop,
	output logic           empty,
	output mfp_pkg::item_t pop_item
);
	import mfp_pkg::*;

	item_t                mem_q [QUEUE_DEPTH];
	logic [QPTR_BITS-1:0] wptr_q, rptr_q;
	logic [QPTR_BITS:0]   count_q;

	assign full     = (count_q == (QPTR_BITS+1)'(QUEUE_DEPTH));
	assign empty    = (count_q == '0);
	assign pop_item = mem_q[rptr_q];

	// store entries
	always_ff @(posedge clk) begin
		if (push) mem_q[wptr_q] <= push_item;
	end

	// advance pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (push) wptr_q <= wptr_q + 1'b1;
			if (pop)  rptr_q <= rptr_q + 1'b1;
			count_q <= count_q + (QPTR_BITS+1)'(push) - (QPTR_BITS+1)'(pop);
		end
	end

endmodule

// ----- rtl/mfp_back.sv -----
// Back part: two-stage pipeline; stage 1 multiplies row by pitch and looks
// up color, stage 2 adds the column and drives the output. Uses mfp_pkg.
module mfp_back (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            q_empty,
	input  mfp_pkg::item_t                  q_item,
	output logic                            pop,
	input  logic [12:0]                     row_pitch,
	output logic                            m_valid,
	input  logic                            m_ready,
	output logic [mfp_pkg::ADDRESS_BITS-1:0] m_address,
	output logic [31:0]                     m_rgba,
	output logic                            m_last
);
	import mfp_pkg::*;

	localparam int PROD_BITS = COORD_BITS + 1 + 13;

	logic                    v_s1, v_s2;
	logic [PROD_BITS-1:0]    prod_s1;
	logic [COORD_BITS:0]     col_s1;
	logic [31:0]             rgba_s1;
	logic                    last_s1;
	logic [ADDRESS_BITS-1:0] addr_s2;
	logic [31:0]             rgba_s2;
	logic                    last_s2;
	logic                    adv2, adv1;
	logic [31:0]             color;
	logic [31:0]             p;
	logic [7:0]              g2, r5, g5, b5;

	assign adv2 = !v_s2 || m_ready;
	assign adv1 = !v_s1 || adv2;
	assign pop  = adv1 && !q_empty;
	assign p    = q_item.pixel;

	// convert the pixel per mode
	always_comb begin
		g2 = 8'd255 - 8'(p[1:0] * 8'd85);
		b5 = {p[4:0], p[4:2]};
		g5 = {p[9:5], p[9:7]};
		r5 = {p[14:10], p[14:12]};
		case (q_item.mode)
			MODE_MONO_BLACK: color = (p[7:0] != '0) ? 32'hFF000000 : 32'hFFFFFFFF;
			MODE_MONO_WHITE: color = (p[15:0] != '0) ? 32'hFFFFFFFF : 32'hFF000000;
			MODE_BRIGHT:     color = swap_rb(BRIGHT_PAL[p[3:0]]);
			MODE_PAL128:     color = {8'hFF, PAL_SMALL[p[6:0]]};
			MODE_GRAY2:      color = {8'hFF, g2, g2, g2};
			MODE_RGB555:     color = {8'hFF, r5, g5, b5};
			MODE_PAL512:     color = swap_rb({8'hFF, PAL_LARGE[p[8:0]]});
			MODE_GRAY4:      color = {8'hFF, {3{p[3:0], 4'h0}}};
			MODE_RGB222:     color = {8'hFF, {4{p[5:4]}}, {4{p[3:2]}}, {4{p[1:0]}}};
			MODE_RGB444:     color = {8'hFF, {2{p[3:0]}}, {2{p[7:4]}}, {2{p[11:8]}}};
			default:         color = p;
		endcase
	end

	// payload stages
	always_ff @(posedge clk) begin
		if (adv1) begin
			prod_s1 <= q_item.row_base * row_pitch;
			col_s1  <= q_item.col;
			rgba_s1 <= color;
			last_s1 <= q_item.last;
		end
		if (adv2) begin
			addr_s2 <= ADDRESS_BITS'(prod_s1) + ADDRESS_BITS'(col_s1);
			rgba_s2 <= rgba_s1;
			last_s2 <= last_s1;
		end
	end

	// valid flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (adv1) v_s1 <= !q_empty;
			if (adv2) v_s2 <= v_s1;
		end
	end

	assign m_valid   = v_s2;
	assign m_address = addr_s2;
	assign m_rgba    = rgba_s2;
	assign m_last    = last_s2;

endmodule

// ----- rtl/multi_format_pixel_to_rgba_top.sv -----
// Top level of the multi-format pixel to RGBA converter.
// Instantiates mfp_front, mfp_queue and mfp_back; uses mfp_pkg.
//
// Usage:
//   s_axis_* carries one source pixel per transaction: tdata holds pixel in
//   bits 31..0 and event_column in bits 43..32.
//   m_axis_* gives one result per pixel: tdata holds address in bits 23..0
//   and rgba in bits 55..24; tlast marks the last pixel of a source frame.
//   The cfg port writes register cfg_index (0 mode, 1 column origin, 2 row
//   origin, 3 row pitch, 4 event view) on any clock with cfg_we high; write
//   only while idle. Writing mode restarts the frame counters.
// Throughput: one pixel per clock while m_axis_tready is high. Registers in
//   order: queue entry, row-times-pitch multiply with color lookup, column
//   add. Pixels taken while mode is an unused code give no result.
// Reset: mode 0, origins 0, row pitch 640, event view off, counters zero,
//   queue and pipeline empty.
// Stall: when m_axis_tready is low the output holds; the four-entry queue
//   absorbs pixels until full, then s_axis_tready drops.
module multi_format_pixel_to_rgba_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [12:0] cfg_data,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [47:0] s_axis_tdata,   // pixel[31:0], event_column[43:32], zero pad
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [63:0] m_axis_tdata,   // address[23:0], rgba[55:24], zero pad
	output logic        m_axis_tlast
);
	import mfp_pkg::*;

	logic        push, full, pop, empty, in_fire;
	item_t       f_item, q_item;
	logic [12:0] row_pitch;
	logic [ADDRESS_BITS-1:0] address;
	logic [31:0] rgba;

	assign s_axis_tready = !full;
	assign in_fire       = s_axis_tvalid && s_axis_tready;

	mfp_front u_front (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_fire(in_fire), .in_pixel(s_axis_tdata[31:0]),
		.in_event_column(s_axis_tdata[32 +: COORD_BITS]),
		.push(push), .item(f_item), .row_pitch(row_pitch)
	);

	mfp_queue u_queue (
		.clk(clk), .arst_n(arst_n),
		.push(push), .push_item(f_item), .full(full),
		.pop(pop), .empty(empty), .pop_item(q_item)
	);

	mfp_back u_back (
		.clk(clk), .arst_n(arst_n),
		.q_empty(empty), .q_item(q_item), .pop(pop), .row_pitch(row_pitch),
		.m_valid(m_axis_tvalid), .m_ready(m_axis_tready),
		.m_address(address), .m_rgba(rgba), .m_last(m_axis_tlast)
	);

	assign m_axis_tdata = {8'd0, rgba, address};

endmodule
